[hw/rtl/q2e_pkg.sv]
// shared types, widths, arctangent table and helpers for the quaternion to euler block
package q2e_pkg;

	localparam int QW = 16;
	localparam int PW = 2 * QW;
	localparam int SW = 34;
	localparam int RW = 29;
	localparam int VW = 57;
	localparam int CW = 36;
	localparam int ZW = 32;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd1 << 28);
	localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

	typedef struct packed {
		logic signed [SW-1:0] s;
		logic signed [SW-1:0] yn;
		logic signed [SW-1:0] yd;
		logic signed [SW-1:0] rn;
		logic signed [SW-1:0] rd;
		logic                 clamped;
	} q2e_side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [ZW-1:0]        z;
	} q2e_vec_t;

	typedef struct packed {
		q2e_vec_t pitch;
		q2e_vec_t yaw;
		q2e_vec_t roll;
		logic     clamped;
	} q2e_set_t;

	function automatic logic [ZW-1:0] atan_entry(input int i);
		logic [ZW-1:0] r;
		unique case (i)
			0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
			15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
			21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
			24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
			27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// fold the left half plane onto the right one
	function automatic q2e_vec_t vec_prep(input logic signed [SW-1:0] num,
			input logic signed [SW-1:0] den);
		q2e_vec_t v;
		if (den < 0) begin
			v.x = -CW'(den);
			v.y = -CW'(num);
			v.z = HALF_TURN;
		end else begin
			v.x = CW'(den);
			v.y = CW'(num);
			v.z = '0;
		end
		return v;
	endfunction

endpackage

[hw/rtl/q2e_in_if.sv]
// quaternion request channel
interface q2e_in_if import q2e_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] quat_w;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

[hw/rtl/q2e_out_if.sv]
// euler angle result channel
interface q2e_out_if #(parameter int ANGLE_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic                         pitch_clamped;

	modport source (output valid, pitch_angle, yaw_angle, roll_angle, pitch_clamped,
		input ready);
	modport sink (input valid, pitch_angle, yaw_angle, roll_angle, pitch_clamped,
		output ready);
endinterface

[hw/rtl/q2e_sqrt_cell.sv]
// one root bit of the pipelined integer square root
module q2e_sqrt_cell import q2e_pkg::*; #(
	parameter int K = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             prev_valid,
	input  logic [VW-1:0]    prev_rem,
	input  logic [RW-1:0]    prev_root,
	input  q2e_side_t        prev_side,
	output logic             valid_q,
	output logic [VW-1:0]    rem_q,
	output logic [RW-1:0]    root_q,
	output q2e_side_t        side_q
);
	logic [VW:0] trial;
	logic        fits;

	always_comb begin
		trial = (((VW+1)'(prev_root) << 1) + ((VW+1)'(1) << K)) << K;
		fits  = trial <= {1'b0, prev_rem};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= prev_side;
			if (fits) begin
				rem_q  <= prev_rem - trial[VW-1:0];
				root_q <= prev_root | (RW'(1) << K);
			end else begin
				rem_q  <= prev_rem;
				root_q <= prev_root;
			end
		end
	end
endmodule

[hw/rtl/q2e_cordic_cell.sv]
// one vectoring cordic iteration for the three angle lanes
module q2e_cordic_cell import q2e_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     prev_valid,
	input  q2e_set_t prev_set,
	output logic     valid_q,
	output q2e_set_t set_q
);
	localparam logic [ZW-1:0] ANG = atan_entry(STEP);

	function automatic q2e_vec_t rotate(input q2e_vec_t v);
		q2e_vec_t r;
		r = v;
		if (v.y > 0) begin
			r.x = v.x + (v.y >>> STEP);
			r.y = v.y - (v.x >>> STEP);
			r.z = v.z + ANG;
		end else if (v.y < 0) begin
			r.x = v.x - (v.y >>> STEP);
			r.y = v.y + (v.x >>> STEP);
			r.z = v.z - ANG;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			set_q.pitch   <= rotate(prev_set.pitch);
			set_q.yaw     <= rotate(prev_set.yaw);
			set_q.roll    <= rotate(prev_set.roll);
			set_q.clamped <= prev_set.clamped;
		end
	end
endmodule

[hw/rtl/quaternion_to_euler_top.sv]
// quaternion to euler angles: products, square root chain, cordic chain, output register
// One quaternion is taken per cycle while the result side keeps up. The pipeline
// holds three arithmetic stages, 29 square root cells, one quadrant fold, the
// cordic cells and the rounding register. The whole pipeline
// advances together, so a result held on the output stalls the input until taken.
// Angles are binary angles with 2^ANGLE_BITS as a full turn; pitch_clamped marks
// an asin argument that lay outside plus or minus one and was saturated.
module quaternion_to_euler_top import q2e_pkg::*; #(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	q2e_in_if.sink  quat_in,
	q2e_out_if.source euler_out
);
	localparam int SH = ZW - ANGLE_BITS;

	logic en;
	logic out_valid_q;

	assign en            = !out_valid_q || euler_out.ready;
	assign quat_in.ready = en;

	// stage 1: products
	logic                 v_s1;
	logic signed [PW-1:0] wx_s1, yz_s1, wy_s1, xz_s1, wz_s1, xy_s1, xx_s1, yy_s1, zz_s1;

	// stage 2: sums and saturation
	logic                 v_s2;
	q2e_side_t            side_s2;
	logic [RW-1:0]        mag_s2;

	// stage 3: radicand
	logic                 v_s3;
	q2e_side_t            side_s3;
	logic [VW-1:0]        rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= quat_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	logic signed [SW-1:0] s_raw, s_sat;
	logic                 sat;

	always_comb begin
		s_raw = (SW'(wx_s1) - SW'(yz_s1)) <<< 1;
		sat   = 1'b0;
		s_sat = s_raw;
		if (s_raw > ONE_Q28) begin
			s_sat = ONE_Q28;
			sat   = 1'b1;
		end else if (s_raw < -ONE_Q28) begin
			s_sat = -ONE_Q28;
			sat   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat_in.quat_w * quat_in.quat_x;
			yz_s1 <= quat_in.quat_y * quat_in.quat_z;
			wy_s1 <= quat_in.quat_w * quat_in.quat_y;
			xz_s1 <= quat_in.quat_x * quat_in.quat_z;
			wz_s1 <= quat_in.quat_w * quat_in.quat_z;
			xy_s1 <= quat_in.quat_x * quat_in.quat_y;
			xx_s1 <= quat_in.quat_x * quat_in.quat_x;
			yy_s1 <= quat_in.quat_y * quat_in.quat_y;
			zz_s1 <= quat_in.quat_z * quat_in.quat_z;

			side_s2.s       <= s_sat;
			side_s2.clamped <= sat;
			side_s2.yn      <= (SW'(wy_s1) + SW'(xz_s1)) <<< 1;
			side_s2.yd      <= ONE_Q28 - ((SW'(xx_s1) + SW'(yy_s1)) <<< 1);
			side_s2.rn      <= (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
			side_s2.rd      <= ONE_Q28 - ((SW'(yy_s1) + SW'(zz_s1)) <<< 1);
			mag_s2          <= s_sat < 0 ? RW'(-s_sat) : RW'(s_sat);

			side_s3 <= side_s2;
			rad_s3  <= (VW'(1) << (VW - 1)) - (VW'(mag_s2) * VW'(mag_s2));
		end
	end

	// square root chain, most significant root bit first
	logic          sq_valid [RW+1];
	logic [VW-1:0] sq_rem   [RW+1];
	logic [RW-1:0] sq_root  [RW+1];
	q2e_side_t     sq_side  [RW+1];

	assign sq_valid[0] = v_s3;
	assign sq_rem[0]   = rad_s3;
	assign sq_root[0]  = '0;
	assign sq_side[0]  = side_s3;

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		q2e_sqrt_cell #(.K(RW - 1 - g)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (sq_valid[g]),
			.prev_rem   (sq_rem[g]),
			.prev_root  (sq_root[g]),
			.prev_side  (sq_side[g]),
			.valid_q    (sq_valid[g+1]),
			.rem_q      (sq_rem[g+1]),
			.root_q     (sq_root[g+1]),
			.side_q     (sq_side[g+1])
		);
	end

	// quadrant fold ahead of the cordic chain
	logic     cd_valid [CORDIC_STEPS+1];
	q2e_set_t cd_set   [CORDIC_STEPS+1];
	logic     prep_valid_q;
	q2e_set_t prep_set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_valid_q <= 1'b0;
		end else if (en) begin
			prep_valid_q <= sq_valid[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_set_q.pitch   <= vec_prep(sq_side[RW].s, SW'(sq_root[RW]));
			prep_set_q.yaw     <= vec_prep(sq_side[RW].yn, sq_side[RW].yd);
			prep_set_q.roll    <= vec_prep(sq_side[RW].rn, sq_side[RW].rd);
			prep_set_q.clamped <= sq_side[RW].clamped;
		end
	end

	assign cd_valid[0] = prep_valid_q;
	assign cd_set[0]   = prep_set_q;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		q2e_cordic_cell #(.STEP(g)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (cd_valid[g]),
			.prev_set   (cd_set[g]),
			.valid_q    (cd_valid[g+1]),
			.set_q      (cd_set[g+1])
		);
	end

	// round half up to the angle width, wrapping at a full turn
	logic [ANGLE_BITS-1:0] pitch_r, yaw_r, roll_r;

	if (SH > 0) begin : g_round
		logic [ZW-1:0] rnd_p, rnd_y, rnd_r;
		always_comb begin
			rnd_p   = cd_set[CORDIC_STEPS].pitch.z + (ZW'(1) << (SH - 1));
			rnd_y   = cd_set[CORDIC_STEPS].yaw.z + (ZW'(1) << (SH - 1));
			rnd_r   = cd_set[CORDIC_STEPS].roll.z + (ZW'(1) << (SH - 1));
			pitch_r = rnd_p[ZW-1:SH];
			yaw_r   = rnd_y[ZW-1:SH];
			roll_r  = rnd_r[ZW-1:SH];
		end
	end else begin : g_plain
		assign pitch_r = cd_set[CORDIC_STEPS].pitch.z;
		assign yaw_r   = cd_set[CORDIC_STEPS].yaw.z;
		assign roll_r  = cd_set[CORDIC_STEPS].roll.z;
	end

	logic [ANGLE_BITS-1:0] pitch_q, yaw_q, roll_q;
	logic                  clamped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cd_valid[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q   <= pitch_r;
			yaw_q     <= yaw_r;
			roll_q    <= roll_r;
			clamped_q <= cd_set[CORDIC_STEPS].clamped;
		end
	end

	assign euler_out.valid         = out_valid_q;
	assign euler_out.pitch_angle   = pitch_q;
	assign euler_out.yaw_angle     = yaw_q;
	assign euler_out.roll_angle    = roll_q;
	assign euler_out.pitch_clamped = clamped_q;
endmodule

[tb/q2e_checker.sv]
// checker: watches both channels, predicts euler angles and compares results
`timescale 1ns / 1ps
module q2e_checker import q2e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	q2e_in_if.sink  quat_mon,
	q2e_out_if.sink euler_mon,
	output int      fail_count,
	output int      pending_count
);

	typedef struct {
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] roll;
		logic               clamped;
	} euler_t;

	euler_t angle_queue[$];
	longint unsigned arctan_lut[32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] vector_angle(longint num, longint den);
		logic [31:0] acc;
		longint nx, ny;
		logic [32:0] rounded;
		acc = '0;
		if (num == 0 && den == 0)
			return '0;
		if (den < 0) begin
			den = -den;
			num = -num;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < 16; i++) begin
			// >>> on longint is a floor shift
			if (num > 0) begin
				nx = den + (num >>> i);
				ny = num - (den >>> i);
				acc += arctan_lut[i];
			end else if (num < 0) begin
				nx = den - (num >>> i);
				ny = num + (den >>> i);
				acc -= arctan_lut[i];
			end else begin
				nx = den;
				ny = num;
			end
			den = nx;
			num = ny;
		end
		rounded = {1'b0, acc} + 33'h8000;
		return rounded[31:16];
	endfunction

	function automatic euler_t predict_angles(longint w, longint x, longint y, longint z);
		euler_t e;
		longint s, c;
		longint unsigned mag;
		e.clamped = 1'b0;
		s = 2 * (w * x - y * z);
		if (s > (64'sd1 << 28)) begin
			s = 64'sd1 << 28;
			e.clamped = 1'b1;
		end else if (s < -(64'sd1 << 28)) begin
			s = -(64'sd1 << 28);
			e.clamped = 1'b1;
		end
		mag = (s < 0) ? -s : s;
		c = root_floor((64'd1 << 56) - mag * mag);
		e.pitch = vector_angle(s, c);
		e.yaw = vector_angle(2 * (w * y + x * z), (64'sd1 << 28) - 2 * (x * x + y * y));
		e.roll = vector_angle(2 * (w * z + x * y), (64'sd1 << 28) - 2 * (y * y + z * z));
		return e;
	endfunction

	assign pending_count = angle_queue.size();

	always @(posedge clk or negedge arst_n) begin
		euler_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (quat_mon.valid && quat_mon.ready)
				angle_queue.push_back(predict_angles(quat_mon.quat_w, quat_mon.quat_x,
					quat_mon.quat_y, quat_mon.quat_z));
			if (euler_mon.valid && euler_mon.ready) begin
				if (angle_queue.size() == 0) begin
					$display("%0t: unexpected result p=%0d y=%0d r=%0d c=%0b", $time,
						euler_mon.pitch_angle, euler_mon.yaw_angle,
						euler_mon.roll_angle, euler_mon.pitch_clamped);
					fail_count <= fail_count + 1;
				end else begin
					e = angle_queue.pop_front();
					if (e.pitch !== euler_mon.pitch_angle || e.yaw !== euler_mon.yaw_angle ||
							e.roll !== euler_mon.roll_angle ||
							e.clamped !== euler_mon.pitch_clamped) begin
						$display("%0t: expected p=%0d y=%0d r=%0d c=%0b got p=%0d y=%0d r=%0d c=%0b",
							$time, e.pitch, e.yaw, e.roll, e.clamped,
							euler_mon.pitch_angle, euler_mon.yaw_angle,
							euler_mon.roll_angle, euler_mon.pitch_clamped);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[tb/testbench.sv]
// testbench top: clock, reset, quaternion requests, result back-pressure and verdict
`timescale 1ns / 1ps
module testbench;
	import q2e_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   cycle_count;
	logic hold_off;
	logic calm;

	q2e_in_if  quat_ch();
	q2e_out_if #(.ANGLE_BITS(16)) euler_ch();

	quaternion_to_euler_top u_top (.clk(clk), .arst_n(arst_n), .quat_in(quat_ch.sink),
		.euler_out(euler_ch.source));

	q2e_checker u_checker (.clk(clk), .arst_n(arst_n), .quat_mon(quat_ch.sink),
		.euler_mon(euler_ch.sink), .fail_count(fail_count), .pending_count(pending_count));

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	always @(posedge clk) begin
		if (cycle_count > 400000) begin
			$display("quaternion_to_euler_top: mismatch");
			$finish;
		end
	end

	// result side: random stalls unless calm or held off
	always @(negedge clk) begin
		if (hold_off)
			euler_ch.ready <= 1'b0;
		else
			euler_ch.ready <= calm || ($urandom_range(99) >= 28);
	end

	// long hold-off so the pipeline fills and stalls the input
	initial begin
		hold_off = 1'b0;
		wait (cycle_count == 200);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (150) @(negedge clk);
		hold_off = 1'b0;
	end

	task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while (!calm && $urandom_range(99) < 28) begin
			quat_ch.valid <= 1'b0;
			@(negedge clk);
		end
		quat_ch.valid <= 1'b1;
		quat_ch.quat_w <= w;
		quat_ch.quat_x <= x;
		quat_ch.quat_y <= y;
		quat_ch.quat_z <= z;
		@(posedge clk);
		while (!quat_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// near-unit quaternion from a random direction
	task automatic send_unit();
		int c[4];
		real n;
		for (int i = 0; i < 4; i++)
			c[i] = $signed(16'($urandom)) ;
		n = $sqrt(real'(c[0]) ** 2 + real'(c[1]) ** 2 + real'(c[2]) ** 2 + real'(c[3]) ** 2);
		if (n < 1.0)
			n = 1.0;
		send_quat(16'($rtoi(c[0] * 16384.0 / n) + $urandom_range(8) - 4),
			16'($rtoi(c[1] * 16384.0 / n)), 16'($rtoi(c[2] * 16384.0 / n)),
			16'($rtoi(c[3] * 16384.0 / n)));
	endtask

	initial begin
		cycle_count = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		quat_ch.valid = 1'b0;
		quat_ch.quat_w = '0;
		quat_ch.quat_x = '0;
		quat_ch.quat_y = '0;
		quat_ch.quat_z = '0;
		euler_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed: identity, axes, zero vector, extremes, clamp both ways, pi wrap
		send_quat(16'd16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_quat(16'h7FFF, 16'h7FFF, 0, 0);
		send_quat(16'h7FFF, 16'h8000, 0, 0);
		send_quat(0, 0, 16'h7FFF, 16'h7FFF);
		send_quat(0, 16'd16384, 0, 0);
		send_quat(0, 0, 16'd16384, 0);
		send_quat(0, 0, 0, 16'd16384);
		send_quat(16'd11585, 16'd11585, 0, 0);
		send_quat(16'd11585, 16'hD2BF, 0, 0);
		send_quat(16'd11585, 0, 16'd11585, 0);
		send_quat(16'd11585, 0, 0, 16'd11585);
		send_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
		send_quat(16'h8000, 0, 0, 0);
		send_quat(0, 16'h8000, 16'h7FFF, 0);
		for (int i = 0; i < 1100; i++) begin
			// calm stretch with no idling on either side
			calm = (i >= 500 && i < 620);
			if (i == 800) begin
				quat_ch.valid <= 1'b0;
				wait (pending_count == 0);
				@(negedge clk);
			end
			if ($urandom_range(99) < 75)
				send_unit();
			else
				send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end
		quat_ch.valid <= 1'b0;
		calm = 1'b0;
		wait (pending_count == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("quaternion_to_euler_top: match");
		else
			$display("quaternion_to_euler_top: mismatch");
		$finish;
	end

endmodule

[quaternion_to_euler_top.f]
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_in_if.sv
hw/rtl/q2e_out_if.sv
hw/rtl/q2e_sqrt_cell.sv
hw/rtl/q2e_cordic_cell.sv
hw/rtl/quaternion_to_euler_top.sv
tb/q2e_checker.sv
tb/testbench.sv
